// ===== rtl/ptd_pkg.sv =====
`default_nettype none
package ptd_pkg;

  // table geometry
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);

  // payload field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned IdW     = 16;
  localparam int unsigned PeriodW = 31;
  localparam int unsigned OccW    = 7;

  // depth of the small queues on both sides of the engine
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // item kind codes
  localparam logic [KindW-1:0] KIND_TICK       = 3'd0;
  localparam logic [KindW-1:0] KIND_ADD        = 3'd1;
  localparam logic [KindW-1:0] KIND_REMOVE     = 3'd2;
  localparam logic [KindW-1:0] KIND_SET_PERIOD = 3'd3;
  localparam logic [KindW-1:0] KIND_SET_ENABLE = 3'd4;
  localparam logic [KindW-1:0] KIND_CLEAR      = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_SET_PERIOD,
    OP_SET_ENABLE,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [TimeW-1:0]   now;
    logic [IdW-1:0]     task_id;
    logic [PeriodW-1:0] period;
    logic               enable;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]  fired_id;
    logic            fired;
    logic [OccW-1:0] fired_count;
    logic            ok;
    logic [OccW-1:0] occupancy;
    logic            last;
  } out_item_t;

  // classified command handed from front to engine
  typedef struct packed {
    op_e                op;
    logic [TimeW-1:0]   now;
    logic [IdW-1:0]     task_id;
    logic [PeriodW-1:0] period;
    logic               enable;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]     task_id;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   last_run;
    logic               enable;
  } slot_t;

  function automatic op_e classify(logic [KindW-1:0] kind);
    op_e op;
    unique case (kind)
      KIND_TICK:       op = OP_TICK;
      KIND_ADD:        op = OP_ADD;
      KIND_REMOVE:     op = OP_REMOVE;
      KIND_SET_PERIOD: op = OP_SET_PERIOD;
      KIND_SET_ENABLE: op = OP_SET_ENABLE;
      KIND_CLEAR:      op = OP_CLEAR;
      default:         op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/periodic_task_dispatcher.sv =====
`default_nettype none
// periodic task dispatcher
//
// input channel: an item is taken on a clock edge with push high and full low.
//   item.kind selects tick, add, remove, set period, set enable or clear all.
// result channel: the oldest result sits on result while empty is low and is
//   taken on a clock edge with pop high and empty low.
// a tick walks the task table in insertion order, one entry per cycle unless
//   a due task meets a full result queue, and gives one beat per due task
//   (last set on the final one) or a single beat with fired low when nothing
//   is due. every other kind gives one beat.
// an item passes through the input queue to the engine; add, set period,
//   set enable and remove walk the table until the id is found, and remove
//   then moves the entries behind it up one per cycle. the engine takes a
//   new command only after its last reply, so its table walk sets the rate.
// both sides carry two-entry queues, so items keep being taken while results
//   wait; a stalled receiver stalls the engine only once its queue is full.
// reset clears the task count, both queues and the engine; the table contents
//   need no reset since only entries below the count are ever read.
module periodic_task_dispatcher (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire ptd_pkg::in_item_t  item_i,
  output logic                    empty,
  input  wire logic               pop,
  output ptd_pkg::out_item_t      result_o
);
  import ptd_pkg::*;

  // front to engine
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;

  // engine to result queue
  logic      res_push;
  out_item_t res;
  logic      res_full;

  // input queue with kind decode
  ptd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // table owner and sequencer
  ptd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // result queue toward the receiver
  ptd_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .res_o   (result_o),
    .empty_o (empty)
  );

endmodule
`default_nettype wire

// ===== rtl/ptd_front.sv =====
`default_nettype none
module ptd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ptd_pkg::in_item_t item_i,
  output logic                   full_o,
  output logic                   cmd_valid_o,
  output ptd_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);
  import ptd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;
  cmd_t             cmd_in;

  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // decode the kind on the way in
  always_comb begin
    cmd_in.op      = classify(item_i.kind);
    cmd_in.now     = item_i.now;
    cmd_in.task_id = item_i.task_id;
    cmd_in.period  = item_i.period;
    cmd_in.enable  = item_i.enable;
  end

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptd_resq.sv =====
`default_nettype none
module ptd_resq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ptd_pkg::out_item_t res_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output ptd_pkg::out_item_t      res_o,
  output logic                    empty_o
);
  import ptd_pkg::*;

  out_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= res_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/ptd_engine.sv =====
`default_nettype none
module ptd_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ptd_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               res_push_o,
  output ptd_pkg::out_item_t res_o,
  input  wire logic          res_full_i
);
  import ptd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TICK  = 5'b00010,
    S_FIND  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_REPLY = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] fcnt_q, fcnt_d;
  logic            pend_q, pend_d;
  logic            ok_q, ok_d;
  cmd_t            cmd_q, cmd_d;
  out_item_t       pend_res_q, pend_res_d;

  slot_t           table_q [MaxTasks];
  logic [CntW-1:0] rd_idx;
  slot_t           rd_entry;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  slot_t           wr_data;

  logic [TimeW-1:0] due_time;
  logic             due;
  logic [CntW-1:0]  idx_inc, fcnt_inc;
  logic [OccW-1:0]  occ;

  // single read port; the shift pass looks one entry ahead
  assign rd_idx   = (state_q == S_SHIFT) ? idx_inc : idx_q;
  assign rd_entry = table_q[rd_idx[IdxW-1:0]];
  assign idx_inc  = idx_q + 1'b1;
  assign fcnt_inc = fcnt_q + 1'b1;
  assign occ      = OccW'(cnt_q);
  assign due_time = rd_entry.last_run + TimeW'(rd_entry.period);
  assign due      = rd_entry.enable && (due_time <= cmd_q.now);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    fcnt_d     = fcnt_q;
    pend_d     = pend_q;
    ok_d       = ok_q;
    cmd_d      = cmd_q;
    pend_res_d = pend_res_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    wr_en      = 1'b0;
    wr_idx     = idx_q[IdxW-1:0];
    wr_data    = rd_entry;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          fcnt_d    = '0;
          pend_d    = 1'b0;
          unique case (cmd_i.op) inside
            OP_TICK: begin
              state_d = S_TICK;
            end
            OP_ADD, OP_REMOVE, OP_SET_PERIOD, OP_SET_ENABLE: begin
              state_d = S_FIND;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              ok_d    = 1'b1;
              state_d = S_REPLY;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = S_REPLY;
            end
          endcase
        end
      end

      S_TICK: begin
        if (idx_q == cnt_q) begin
          // end of walk: flush the held result, or report nothing due
          if (!res_full_i) begin
            res_push_o = 1'b1;
            if (pend_q) begin
              res_o      = pend_res_q;
              res_o.last = 1'b1;
            end else begin
              res_o.ok        = 1'b1;
              res_o.occupancy = occ;
              res_o.last      = 1'b1;
            end
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end else if (due) begin
          if (!(pend_q && res_full_i)) begin
            res_push_o                = pend_q;
            res_o                     = pend_res_q;
            wr_en                     = 1'b1;
            wr_data.last_run          = cmd_q.now;
            pend_d                    = 1'b1;
            pend_res_d.fired_id       = rd_entry.task_id;
            pend_res_d.fired          = 1'b1;
            pend_res_d.fired_count    = OccW'(fcnt_inc);
            pend_res_d.ok             = 1'b1;
            pend_res_d.occupancy      = occ;
            pend_res_d.last           = 1'b0;
            fcnt_d                    = fcnt_inc;
            idx_d                     = idx_inc;
          end
        end else begin
          idx_d = idx_inc;
        end
      end

      S_FIND: begin
        if (idx_q == cnt_q) begin
          // id not in table
          ok_d    = 1'b0;
          state_d = S_REPLY;
          if (cmd_q.op == OP_ADD && cnt_q < CntW'(MaxTasks)) begin
            wr_en            = 1'b1;
            wr_idx           = cnt_q[IdxW-1:0];
            wr_data.task_id  = cmd_q.task_id;
            wr_data.period   = cmd_q.period;
            wr_data.last_run = '0;
            wr_data.enable   = cmd_q.enable;
            cnt_d            = cnt_q + 1'b1;
            ok_d             = 1'b1;
          end
        end else if (rd_entry.task_id == cmd_q.task_id) begin
          ok_d    = 1'b1;
          state_d = S_REPLY;
          case (cmd_q.op)
            OP_SET_PERIOD: begin
              wr_en          = 1'b1;
              wr_data.period = cmd_q.period;
            end
            OP_SET_ENABLE: begin
              wr_en          = 1'b1;
              wr_data.enable = cmd_q.enable;
            end
            OP_REMOVE: begin
              state_d = S_SHIFT;
            end
            default: begin
              // duplicate id on add
              ok_d = 1'b0;
            end
          endcase
        end else begin
          idx_d = idx_inc;
        end
      end

      S_SHIFT: begin
        if (idx_inc < cnt_q) begin
          wr_en = 1'b1;
          idx_d = idx_inc;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          ok_d    = 1'b1;
          state_d = S_REPLY;
        end
      end

      S_REPLY: begin
        if (!res_full_i) begin
          res_push_o      = 1'b1;
          res_o.ok        = ok_q;
          res_o.occupancy = occ;
          res_o.last      = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      fcnt_q  <= '0;
      pend_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      fcnt_q  <= fcnt_d;
      pend_q  <= pend_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pend_res_q <= pend_res_d;
    if (wr_en) begin
      table_q[wr_idx] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTasks))
    else $error("task count above table size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == S_TICK)
    else $error("held result outside tick walk");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_FIND || state_q == S_SHIFT) |-> idx_q <= cnt_q)
    else $error("walk index past table end");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> state_q != S_IDLE)
    else $error("command taken but engine stayed idle");

endmodule
`default_nettype wire
